// ===== design/echo_median_distance_filter_defines.svh =====
// Assertion helpers used by the filter top-level RTL
`ifndef ECHO_MEDIAN_DISTANCE_FILTER_DEFINES_SVH
`define ECHO_MEDIAN_DISTANCE_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define EMDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define EMDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/emdf_pkg.sv =====
package emdf_pkg;

    // Set size and derived widths
    localparam int SAMPLES = 15;
    localparam int IDX_W   = $clog2(SAMPLES);
    localparam int MID_IDX = SAMPLES / 2;

    // Field widths
    localparam int ECHO_W = 16;
    localparam int DIST_W = 11;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    // Divide by 58 as multiply by ceil(2^22 / 58), exact for 16-bit inputs
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = ECHO_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((1 << RECIP_SHIFT) + 57) / 58);

    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = DIST_W'(6);
    localparam logic [IDX_W-1:0]  LAST_IDX       = IDX_W'(SAMPLES - 1);

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // Command into the insertion unit
    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] pos;
    } ins_cmd_t;

    // Status from the insertion unit
    typedef struct packed {
        logic done;
    } ins_stat_t;

endpackage

// ===== design/echo_median_distance_filter.sv =====
// Each accepted item is inserted by the single compare-and-shift insertion unit, which walks
// from n (items already in the set) down to the sorted slot k where the new value lands;
// no new item is taken until the insertion is done. The last item of a set then passes
// through the emit state, which loads the result register and raises m_tvalid.
// Reset (aresetn low, synchronous): set count cleared, near limit back to 6, no result pending.
module echo_median_distance_filter import emdf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] echo_us
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [10:0] distance_cm, [15:11] zero
    input  logic                   cfg_we,
    input  logic [DIST_W-1:0]      cfg_wdata  // near_limit_cm
);

`include "echo_median_distance_filter_defines.svh"

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [DIST_W-1:0] near_reg;
    logic              m_valid_reg, m_valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic              in_acc;
    logic [DIST_W-1:0] key_cm;
    logic [DIST_W-1:0] min_cm;
    logic [DIST_W-1:0] mid_cm;
    ins_cmd_t          ins_cmd;
    ins_stat_t         ins_stat;

    // Hold off the closing item of a set while the previous result is unread
    assign s_tready = (state_reg == ST_IDLE) && !(m_valid_reg && (cnt_reg == LAST_IDX));
    assign in_acc   = s_tvalid && s_tready;

    assign ins_cmd.start = in_acc;
    assign ins_cmd.pos   = cnt_reg;

    emdf_div58 u_div (
        .aclk    (aclk),
        .load    (in_acc),
        .echo_us (s_tdata[ECHO_W-1:0]),
        .quot_cm (key_cm)
    );

    emdf_ins u_ins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ins_cmd),
        .key     (key_cm),
        .stat    (ins_stat),
        .min_cm  (min_cm),
        .mid_cm  (mid_cm)
    );

    // Sequencer and result register
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        dist_next    = dist_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (ins_stat.done) begin
                    if (cnt_reg == LAST_IDX) begin
                        state_next = ST_EMIT;
                    end else begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                // guarded minimum wins over the median
                dist_next    = (min_cm < near_reg) ? min_cm : mid_cm;
                m_valid_next = 1'b1;
                cnt_next     = '0;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            near_reg    <= NEAR_LIMIT_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                near_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(dist_reg);

    `EMDF_ASSERT_NEXT(a_acc_starts_insert, in_acc, state_reg == ST_INSERT,
        "accepted item did not start insertion")
    `EMDF_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_reg <= LAST_IDX,
        "set count beyond set size")
    `EMDF_ASSERT_NOW(a_emit_slot_free, state_reg == ST_EMIT, !m_valid_reg,
        "result loaded over an unread result")
    `EMDF_ASSERT_NOW(a_done_in_insert, ins_stat.done, state_reg == ST_INSERT,
        "insertion finished outside insert state")

endmodule

// ===== design/emdf_div58.sv =====
module emdf_div58 import emdf_pkg::*; (
    input  logic              aclk,
    input  logic              load,
    input  logic [ECHO_W-1:0] echo_us,
    output logic [DIST_W-1:0] quot_cm
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // Reciprocal multiply, registered before use
    assign prod_next = PROD_W'(echo_us) * PROD_W'(RECIP_M);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign quot_cm = prod_reg[RECIP_SHIFT +: DIST_W];

endmodule

// ===== design/emdf_ins.sv =====
module emdf_ins import emdf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  ins_cmd_t          cmd,
    input  logic [DIST_W-1:0] key,
    output ins_stat_t         stat,
    output logic [DIST_W-1:0] min_cm,
    output logic [DIST_W-1:0] mid_cm
);

    // Sorted store, ascending; entries past the fill point are don't-care
    logic [DIST_W-1:0] store_reg [SAMPLES];
    logic              active_reg, active_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;

    logic [IDX_W-1:0]  rd_idx;
    logic [DIST_W-1:0] prev;
    logic              place;
    logic [DIST_W-1:0] wr_data;

    // One compare per cycle: shift the larger neighbor up or drop the key in
    assign rd_idx  = (pos_reg == '0) ? '0 : pos_reg - IDX_W'(1);
    assign prev    = store_reg[rd_idx];
    assign place   = (pos_reg == '0) || (prev <= key);
    assign wr_data = place ? key : prev;

    always_comb begin
        active_next = active_reg;
        pos_next    = pos_reg;
        if (cmd.start) begin
            active_next = 1'b1;
            pos_next    = cmd.pos;
        end else if (active_reg) begin
            if (place) begin
                active_next = 1'b0;
            end else begin
                pos_next = rd_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (active_reg) begin
            store_reg[pos_reg] <= wr_data;
        end
    end

    assign stat.done = active_reg && place;
    assign min_cm    = store_reg[0];
    assign mid_cm    = store_reg[MID_IDX];

endmodule
